>>> sv/sts_pkg.sv
// Shared types for the sorted table interval search block.
package sts_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_SEARCH,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_MID
    } t_addr_sel;

    typedef enum logic [1:0] {
        BND_HOLD,
        BND_INIT,
        BND_STEP
    } t_bnd_op;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_ONE,
        POS_COUNT,
        POS_LOWER
    } t_pos_sel;

    typedef struct packed {
        logic      append;
        logic      clear;
        logic      latch_key;
        t_addr_sel addr_sel;
        t_bnd_op   bnd_op;
        logic      set_result;
        t_pos_sel  pos_sel;
        logic      load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic key_le_rd;
        logic rd_le_key;
        logic nxt_adjacent;
        logic out_free;
    } t_dp_sts;

endpackage

>>> sv/sts_in_if.sv
// Input channel: command and value with valid/ready.
interface sts_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   cmd;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> sv/sts_out_if.sv
// Output channel: interval position with valid/ready.
interface sts_out_if #(
    parameter int POS_BITS = 11
);
    logic                valid;
    logic                ready;
    logic [POS_BITS-1:0] position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

>>> sv/sts_ctrl.sv
// Controller state machine: sequences appends, clears and the query search.
module sts_ctrl
    import sts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_cmd,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_sts    i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{append: 1'b0, clear: 1'b0, latch_key: 1'b0,
                       addr_sel: ADDR_FIRST, bnd_op: BND_HOLD,
                       set_result: 1'b0, pos_sel: POS_ZERO, load_out: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_cmd'(i_in_cmd))
                        CMD_APPEND: o_cmd.append = 1'b1;
                        CMD_CLEAR:  o_cmd.clear  = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.latch_key = 1'b1;
                            o_cmd.addr_sel  = ADDR_FIRST;
                            if (i_sts.empty) begin
                                o_cmd.set_result = 1'b1;
                                o_cmd.pos_sel    = POS_ZERO;
                                n_state          = S_EMIT;
                            end else begin
                                n_state = S_RD_FIRST;
                            end
                        end
                        default: ;  // unused code: dropped
                    endcase
                end
            end
            S_RD_FIRST: begin
                if (i_sts.key_le_rd) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.pos_sel    = POS_ONE;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.addr_sel = ADDR_LAST;
                    n_state        = S_RD_LAST;
                end
            end
            S_RD_LAST: begin
                if (i_sts.rd_le_key) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.pos_sel    = POS_COUNT;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.bnd_op   = BND_INIT;
                    o_cmd.addr_sel = ADDR_MID;
                    if (i_sts.nxt_adjacent) begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.pos_sel    = POS_LOWER;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // read data is the entry at the midpoint of the current bounds
                o_cmd.bnd_op   = BND_STEP;
                o_cmd.addr_sel = ADDR_MID;
                if (i_sts.nxt_adjacent) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.pos_sel    = POS_LOWER;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("emit did not return to idle");

    a_search_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && i_sts.nxt_adjacent) |=> (r_state == S_EMIT))
        else $error("search did not stop at adjacent bounds");

    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_cmd == CMD_QUERY && !i_sts.empty)
        |=> (r_state == S_RD_FIRST))
        else $error("query on filled table did not read first entry");

endmodule

>>> sv/sts_dpath.sv
// Datapath: table memory, entry count, search bounds, compare and output register.
module sts_dpath
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32,
    parameter int IDX_BITS    = $clog2(TABLE_DEPTH),
    parameter int CNT_BITS    = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [CNT_BITS-1:0]          o_position
);

    logic [VALUE_BITS-1:0]        r_table [TABLE_DEPTH];
    logic signed [VALUE_BITS-1:0] r_rd;
    logic signed [VALUE_BITS-1:0] r_key;
    logic [CNT_BITS-1:0]          r_count;
    logic [IDX_BITS-1:0]          r_lo;
    logic [IDX_BITS-1:0]          r_hi;
    logic [CNT_BITS-1:0]          r_result;
    logic [CNT_BITS-1:0]          r_pos;
    logic                         r_out_valid;

    logic [IDX_BITS-1:0] n_lo;
    logic [IDX_BITS-1:0] n_hi;
    logic [IDX_BITS:0]   cur_sum;
    logic [IDX_BITS-1:0] cur_mid;
    logic [IDX_BITS:0]   nxt_sum;
    logic [IDX_BITS:0]   nxt_diff;
    logic [IDX_BITS-1:0] last_idx;
    logic [IDX_BITS-1:0] rd_addr;
    logic                full;
    logic                key_le_rd;
    logic [CNT_BITS-1:0] n_result;

    assign full      = (r_count == CNT_BITS'(TABLE_DEPTH));
    assign last_idx  = IDX_BITS'(r_count - CNT_BITS'(1));
    assign key_le_rd = (r_key <= r_rd);
    assign cur_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign cur_mid   = cur_sum[IDX_BITS:1];

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        case (i_cmd.bnd_op)
            BND_INIT: begin
                n_lo = '0;
                n_hi = last_idx;
            end
            BND_STEP: begin
                if (key_le_rd) begin
                    n_hi = cur_mid;
                end else begin
                    n_lo = cur_mid;
                end
            end
            default: ;
        endcase
    end

    assign nxt_sum  = {1'b0, n_lo} + {1'b0, n_hi};
    assign nxt_diff = {1'b0, n_hi} - {1'b0, n_lo};

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_LAST: rd_addr = last_idx;
            ADDR_MID:  rd_addr = nxt_sum[IDX_BITS:1];
            default:   rd_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.pos_sel)
            POS_ONE:   n_result = CNT_BITS'(1);
            POS_COUNT: n_result = r_count;
            POS_LOWER: n_result = CNT_BITS'(n_lo) + CNT_BITS'(1);
            default:   n_result = '0;
        endcase
    end

    // table storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_table[r_count[IDX_BITS-1:0]] <= i_value;
        end
        r_rd <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_key) begin
            r_key <= i_value;
        end
        if (i_cmd.set_result) begin
            r_result <= n_result;
        end
        if (i_cmd.load_out) begin
            r_pos <= r_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lo        <= '0;
            r_hi        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append && !full) begin
                r_count <= r_count + CNT_BITS'(1);
            end
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.empty        = (r_count == '0);
    assign o_sts.key_le_rd    = key_le_rd;
    assign o_sts.rd_le_key    = (r_rd <= r_key);
    assign o_sts.nxt_adjacent = (nxt_diff < (IDX_BITS + 1)'(2));
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_position  = r_pos;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_step_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.bnd_op == BND_STEP) |-> ({1'b0, r_hi} - {1'b0, r_lo} >= (IDX_BITS + 1)'(2)))
        else $error("search step with adjacent or crossed bounds");

    a_append_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.append && !full && !i_cmd.clear)
        |=> (r_count == $past(r_count) + CNT_BITS'(1)))
        else $error("append did not advance entry count");

endmodule

>>> sv/sorted_table_interval_search.sv
// Top level of the sorted table interval search block.
//
// Input channel i_in carries a command and a signed fixed-point value:
// append writes the value at the end of the table (dropped when full),
// clear empties the table, query searches the table for the value.
// Output channel o_out returns one 1-based interval position per query:
// 0 for an empty table, 1 at or below the first entry, the entry count at
// or above the last entry, otherwise lower+1 after the binary search.
// Append and clear give no transaction out. A query reads the first entry,
// then the last entry, then runs the binary search until the bounds are
// adjacent, and then emits its result; each search step is one read of the
// table memory plus a compare.
// The result sits in an output register: the block takes new items while it
// waits, but a following query stalls in its emit state until the receiver
// takes the earlier result.
// Reset (synchronous, active low) empties the table and drops any pending
// result; memory contents are not cleared and need no clearing pass.
module sorted_table_interval_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_BITS  = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sts_in_if.sink    i_in,
    sts_out_if.source o_out
);

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    sts_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS),
        .IDX_BITS    (IDX_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_in.value),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_position  (o_out.position)
    );

endmodule
